[rtl/core/ngsk_pkg.sv]
// Shared constants, types and helper functions for the n-gram score top-k block.
package ngsk_pkg;

    // Block dimensions
    localparam int MAX_LETTERS = 8;
    localparam int SLOTS       = 16;
    localparam int ALPHABET    = 26;
    localparam int FRAC_BITS   = 24;

    // Derived widths and depths
    localparam int LETTER_W   = 5;
    localparam int WORD_W     = MAX_LETTERS * LETTER_W;
    localparam int PAIR_DEPTH = ALPHABET * ALPHABET;
    localparam int TRI_DEPTH  = ALPHABET * ALPHABET * ALPHABET;
    localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
    localparam int TRI_AW     = $clog2(TRI_DEPTH);
    localparam int VAL_W      = FRAC_BITS;
    localparam int SCORE_W    = 29;
    localparam int SUM_W      = SCORE_W - 1;
    localparam int SLOT_AW    = $clog2(SLOTS);
    localparam int LEN_W      = 4;
    localparam int OPC_W      = 3;
    localparam int IDX_W      = 15;
    localparam int SEL_W      = 4;

    // Stream packing
    localparam int IN_FIELDS_W  = IDX_W + VAL_W + WORD_W + SEL_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SCORE_W + SLOT_AW + WORD_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int OUT_TUSER_W  = 2;

    // Word length bounds and reset value
    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LETTERS);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LETTERS);

    typedef logic [LETTER_W-1:0]      t_letter;
    typedef logic signed [SCORE_W-1:0] t_score;

    // Reset score of slot 0
    localparam t_score SLOT0_SCORE = t_score'(-1);

    typedef enum logic [OPC_W-1:0] {
        OP_WR_FIRST = 3'd0,
        OP_WR_LAST  = 3'd1,
        OP_WR_TRI   = 3'd2,
        OP_SCORE    = 3'd3,
        OP_READ     = 3'd4
    } t_opcode;

    // Letter codes past the alphabet clamp to its last letter
    function automatic t_letter sat_letter(input t_letter l);
        return (l >= LETTER_W'(ALPHABET)) ? LETTER_W'(ALPHABET - 1) : l;
    endfunction

    // a*ALPHABET + b
    function automatic logic [PAIR_AW-1:0] pair_addr(input t_letter a, input t_letter b);
        return PAIR_AW'(a) * PAIR_AW'(ALPHABET) + PAIR_AW'(b);
    endfunction

    // (a*ALPHABET + b)*ALPHABET + c
    function automatic logic [TRI_AW-1:0] tri_addr(input t_letter a, input t_letter b,
                                                   input t_letter c);
        return TRI_AW'(pair_addr(a, b)) * TRI_AW'(ALPHABET) + TRI_AW'(c);
    endfunction

endpackage

[rtl/core/ngram_score_top_k.sv]
// Top level: table memories, slot memory and the scoring sequencer.
//
// Trigram score top-k keeper. Write requests load the first-pair, last-pair and trigram
// tables (unsigned Q0.24); table contents are undefined until written, so there is no
// clearing pass after reset. A score request is accepted, issues its n-2 trigram reads
// through the single trigram memory port and drains them (n is the word length, 2..8),
// leaves the summing state, adds the pair entries, scans the kept slots through the slot
// memory's single read port, decides and writes back, and hands over the result. One
// request is in work at a time; a finished result waits in the output register while
// the next request is accepted and worked on. Configuration writes are always taken and
// must only be issued while the block is idle.
module ngram_score_top_k
    import ngsk_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration: word_length
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [LEN_W-1:0]        i_cfg_data,
    // Request stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata: table_index[14:0], table_value[38:15], word_letters[78:39],
    //        slot_select[82:79], zero pad
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: opcode[2:0]
    input  logic [OPC_W-1:0]        s_axis_tuser,
    // Result stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tdata: score[28:0], slot_index[32:29], slot_letters[72:33], zero pad
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    // tuser: inserted[0], duplicate[1]
    output logic [OUT_TUSER_W-1:0]  m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRI,
        S_PAIRADD,
        S_SCAN,
        S_DEC,
        S_RDSLOT,
        S_RDOUT,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [LEN_W-1:0]     r_word_len;

    // Request fields
    t_opcode              in_op;
    logic [IDX_W-1:0]     in_idx;
    logic [VAL_W-1:0]     in_val;
    logic [WORD_W-1:0]    in_letters;
    logic [SEL_W-1:0]     in_sel;
    logic                 accept;

    // Word preparation
    logic [LEN_W-1:0]     len_c;
    logic [WORD_W-1:0]    clean_word;
    t_letter              lp_a;
    t_letter              lp_b;

    // Scoring registers
    logic [WORD_W-1:0]    r_word;
    logic [WORD_W-1:0]    r_sh;
    logic [PAIR_AW-1:0]   r_fp_addr;
    logic [PAIR_AW-1:0]   r_lp_addr;
    logic [LEN_W-1:0]     r_tri_left;
    logic                 r_tri_vld;
    logic [SUM_W-1:0]     r_sum;
    logic                 r_zero;
    t_score               r_score;
    logic                 r_dup;
    t_score               r_min_score;
    logic [SLOT_AW-1:0]   r_min_idx;

    // Table memories
    logic [VAL_W-1:0]     mem_fp  [PAIR_DEPTH];
    logic [VAL_W-1:0]     mem_lp  [PAIR_DEPTH];
    logic [VAL_W-1:0]     mem_tri [TRI_DEPTH];
    logic [VAL_W-1:0]     r_fp_q;
    logic [VAL_W-1:0]     r_lp_q;
    logic [VAL_W-1:0]     r_tri_q;
    logic [TRI_AW-1:0]    tri_rd_addr;
    logic                 wr_fp;
    logic                 wr_lp;
    logic                 wr_tri;

    // Slot memory with per-slot valid bits
    t_score               mem_sscore [SLOTS];
    logic [WORD_W-1:0]    mem_sword  [SLOTS];
    logic [SLOTS-1:0]     r_slot_vld;
    logic [SLOT_AW-1:0]   r_slot_raddr;
    logic                 r_scan_iss;
    logic                 r_q_live;
    t_score               r_sq_score;
    logic [WORD_W-1:0]    r_sq_word;
    logic                 r_sq_vld;
    logic [SLOT_AW-1:0]   r_sq_addr;
    t_score               sq_score;
    logic [WORD_W-1:0]    sq_word;
    logic                 ins_now;

    // Result staging and output register
    t_score               r_res_score;
    logic                 r_res_ins;
    logic                 r_res_dup;
    logic [SLOT_AW-1:0]   r_res_idx;
    logic [WORD_W-1:0]    r_res_letters;
    logic                 r_m_valid;
    t_score               r_m_score;
    logic                 r_m_ins;
    logic                 r_m_dup;
    logic [SLOT_AW-1:0]   r_m_idx;
    logic [WORD_W-1:0]    r_m_letters;

    // Request unpacking
    assign in_op      = t_opcode'(s_axis_tuser);
    assign in_idx     = s_axis_tdata[IDX_W-1:0];
    assign in_val     = s_axis_tdata[IDX_W +: VAL_W];
    assign in_letters = s_axis_tdata[IDX_W + VAL_W +: WORD_W];
    assign in_sel     = s_axis_tdata[IDX_W + VAL_W + WORD_W +: SEL_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Clamp length, saturate letters, clear letters past the word, pick the last pair
    always_comb begin
        len_c = r_word_len;
        if (r_word_len < LEN_MIN) begin
            len_c = LEN_MIN;
        end else if (r_word_len > LEN_MAX) begin
            len_c = LEN_MAX;
        end
        for (int i = 0; i < MAX_LETTERS; i++) begin
            clean_word[i*LETTER_W +: LETTER_W] =
                (i < int'(len_c)) ? sat_letter(in_letters[i*LETTER_W +: LETTER_W]) : '0;
        end
        lp_a = '0;
        lp_b = '0;
        for (int k = 2; k <= MAX_LETTERS; k++) begin
            if (len_c == LEN_W'(k)) begin
                lp_a = clean_word[(k-2)*LETTER_W +: LETTER_W];
                lp_b = clean_word[(k-1)*LETTER_W +: LETTER_W];
            end
        end
    end

    // Trigram read address from the low three letters of the shifting word
    assign tri_rd_addr = tri_addr(r_sh[0 +: LETTER_W], r_sh[LETTER_W +: LETTER_W],
                                  r_sh[2*LETTER_W +: LETTER_W]);

    assign wr_fp  = accept && (in_op == OP_WR_FIRST) && (in_idx < IDX_W'(PAIR_DEPTH));
    assign wr_lp  = accept && (in_op == OP_WR_LAST)  && (in_idx < IDX_W'(PAIR_DEPTH));
    assign wr_tri = accept && (in_op == OP_WR_TRI)   && (in_idx < IDX_W'(TRI_DEPTH));

    // Table memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (wr_fp) begin
            mem_fp[in_idx[PAIR_AW-1:0]] <= in_val;
        end
        r_fp_q <= mem_fp[r_fp_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_lp) begin
            mem_lp[in_idx[PAIR_AW-1:0]] <= in_val;
        end
        r_lp_q <= mem_lp[r_lp_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_tri) begin
            mem_tri[in_idx[TRI_AW-1:0]] <= in_val;
        end
        r_tri_q <= mem_tri[tri_rd_addr];
    end

    // Insert when not a duplicate and strictly above the lowest kept score
    assign ins_now = (r_state == S_DEC) && !r_dup && (r_score > r_min_score);

    // Slot memory: written on insert, read at the scan or read-request address
    always_ff @(posedge i_clk) begin
        if (ins_now) begin
            mem_sscore[r_min_idx] <= r_score;
            mem_sword[r_min_idx]  <= r_word;
        end
        r_sq_score <= mem_sscore[r_slot_raddr];
        r_sq_word  <= mem_sword[r_slot_raddr];
        r_sq_vld   <= r_slot_vld[r_slot_raddr];
        r_sq_addr  <= r_slot_raddr;
    end

    // A slot never written reads as its reset value
    assign sq_score = r_sq_vld ? r_sq_score
                    : ((r_sq_addr == '0) ? SLOT0_SCORE : '0);
    assign sq_word  = r_sq_vld ? r_sq_word : '0;

    // Sequencer, control state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_word_len <= LEN_RESET;
            r_slot_vld <= '0;
            r_tri_vld  <= 1'b0;
            r_scan_iss <= 1'b0;
            r_q_live   <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_word_len <= i_cfg_data;
            end
            if (r_m_valid && m_axis_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            // A trigram read is in flight after every issuing cycle
            r_tri_vld <= (r_state == S_TRI) && (r_tri_left != '0);
            r_q_live  <= r_scan_iss;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_score   <= '0;
                        r_res_ins     <= 1'b0;
                        r_res_dup     <= 1'b0;
                        r_res_idx     <= '0;
                        r_res_letters <= '0;
                        unique case (in_op)
                            OP_SCORE: begin
                                r_word     <= clean_word;
                                r_sh       <= clean_word;
                                r_fp_addr  <= pair_addr(clean_word[0 +: LETTER_W],
                                                        clean_word[LETTER_W +: LETTER_W]);
                                r_lp_addr  <= pair_addr(lp_a, lp_b);
                                r_tri_left <= len_c - LEN_MIN;
                                r_sum      <= '0;
                                r_zero     <= 1'b0;
                                r_state    <= S_TRI;
                            end
                            OP_READ: begin
                                r_slot_raddr <= in_sel[SLOT_AW-1:0];
                                r_state      <= S_RDSLOT;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end

                // One trigram read issued per cycle, summed as it returns
                S_TRI: begin
                    if (r_tri_left != '0) begin
                        r_sh       <= r_sh >> LETTER_W;
                        r_tri_left <= r_tri_left - 1'b1;
                    end
                    if (r_tri_vld) begin
                        if (r_tri_q == '0) begin
                            r_zero <= 1'b1;
                        end
                        r_sum <= r_sum + SUM_W'(r_tri_q);
                    end
                    if ((r_tri_left == '0) && !r_tri_vld) begin
                        r_state <= S_PAIRADD;
                    end
                end

                // Add the pair entries; a zero trigram forces the score to zero
                S_PAIRADD: begin
                    r_score      <= r_zero ? '0
                                  : t_score'({1'b0, r_sum + SUM_W'(r_fp_q) + SUM_W'(r_lp_q)});
                    r_slot_raddr <= '0;
                    r_scan_iss   <= 1'b1;
                    r_dup        <= 1'b0;
                    r_state      <= S_SCAN;
                end

                // Walk the slots: duplicate check and lowest score, lowest index on ties
                S_SCAN: begin
                    if (r_scan_iss) begin
                        if (r_slot_raddr == SLOT_AW'(SLOTS - 1)) begin
                            r_scan_iss <= 1'b0;
                        end else begin
                            r_slot_raddr <= r_slot_raddr + 1'b1;
                        end
                    end
                    if (r_q_live) begin
                        if ((sq_score == r_score) && (sq_word == r_word)) begin
                            r_dup <= 1'b1;
                        end
                        if ((r_sq_addr == '0) || (r_min_score > sq_score)) begin
                            r_min_score <= sq_score;
                            r_min_idx   <= r_sq_addr;
                        end
                        if (r_sq_addr == SLOT_AW'(SLOTS - 1)) begin
                            r_state <= S_DEC;
                        end
                    end
                end

                S_DEC: begin
                    r_res_score <= r_score;
                    r_res_dup   <= r_dup;
                    if (ins_now) begin
                        r_slot_vld[r_min_idx] <= 1'b1;
                        r_res_ins             <= 1'b1;
                        r_res_idx             <= r_min_idx;
                    end
                    r_state <= S_OUT;
                end

                S_RDSLOT: begin
                    r_state <= S_RDOUT;
                end

                S_RDOUT: begin
                    r_res_score   <= sq_score;
                    r_res_idx     <= r_sq_addr;
                    r_res_letters <= sq_word;
                    r_state       <= S_OUT;
                end

                // Hand over once the output register is free
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid   <= 1'b1;
                        r_m_score   <= r_res_score;
                        r_m_ins     <= r_res_ins;
                        r_m_dup     <= r_res_dup;
                        r_m_idx     <= r_res_idx;
                        r_m_letters <= r_res_letters;
                        r_state     <= S_IDLE;
                    end else begin
                        r_m_valid <= 1'b1;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result packing
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_m_letters, r_m_idx, r_m_score};
    assign m_axis_tuser  = {r_m_dup, r_m_ins};

`ifndef SYNTHESIS
    // A word is never both inserted and reported as a duplicate
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !(r_m_ins && r_m_dup))
        else $error("inserted and duplicate both set");

    // Trigram data in flight only while summing
    a_tri_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tri_vld |-> (r_state == S_TRI))
        else $error("trigram read data outside the summing state");

    // Slot scan data arrives only during the scan
    a_scan_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_live |-> (r_state == S_SCAN))
        else $error("slot scan data outside the scan");

    // An inserted slot is marked written afterwards
    a_insert_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins_now |=> r_slot_vld[$past(r_min_idx)])
        else $error("inserted slot not marked valid");
`endif

endmodule
